// ===== rtl/c8x_pkg.sv =====
// shared constants, codes and controller/datapath types for the chip-8 executor
package c8x_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int MEM_BYTES   = 4096;
  localparam int ADDR_W      = $clog2(MEM_BYTES);
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int ROW_W       = $clog2(SCREEN_H);
  localparam int COL_W       = $clog2(SCREEN_W);

  localparam logic [ADDR_W-1:0] PC_START   = 12'h200;
  localparam logic [ADDR_W-1:0] FONT_RESET = 12'd80;

  // item kinds
  localparam logic [2:0] KIND_LOAD = 3'd0;
  localparam logic [2:0] KIND_EXEC = 3'd1;
  localparam logic [2:0] KIND_READ = 3'd2;
  localparam logic [2:0] KIND_ROW  = 3'd3;
  localparam logic [2:0] KIND_TICK = 3'd4;

  // opcode groups and sub-codes
  localparam logic [15:0] OP_CLS   = 16'h00E0;
  localparam logic [15:0] OP_RET   = 16'h00EE;
  localparam logic [3:0]  GRP_SYS  = 4'h0;
  localparam logic [3:0]  GRP_JP   = 4'h1;
  localparam logic [3:0]  GRP_CALL = 4'h2;
  localparam logic [3:0]  GRP_SEI  = 4'h3;
  localparam logic [3:0]  GRP_SNEI = 4'h4;
  localparam logic [3:0]  GRP_SE   = 4'h5;
  localparam logic [3:0]  GRP_LDI  = 4'h6;
  localparam logic [3:0]  GRP_ADDI = 4'h7;
  localparam logic [3:0]  GRP_ALU  = 4'h8;
  localparam logic [3:0]  GRP_SNE  = 4'h9;
  localparam logic [3:0]  GRP_SETI = 4'hA;
  localparam logic [3:0]  GRP_JPV0 = 4'hB;
  localparam logic [3:0]  GRP_RND  = 4'hC;
  localparam logic [3:0]  GRP_DRW  = 4'hD;
  localparam logic [3:0]  GRP_KEY  = 4'hE;
  localparam logic [3:0]  GRP_MISC = 4'hF;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_RSB = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] NN_SKP   = 8'h9E;
  localparam logic [7:0] NN_SKNP  = 8'hA1;
  localparam logic [7:0] NN_GETDT = 8'h07;
  localparam logic [7:0] NN_WAITK = 8'h0A;
  localparam logic [7:0] NN_SETDT = 8'h15;
  localparam logic [7:0] NN_SETST = 8'h18;
  localparam logic [7:0] NN_ADDIX = 8'h1E;
  localparam logic [7:0] NN_FONT  = 8'h29;
  localparam logic [7:0] NN_BCD   = 8'h33;
  localparam logic [7:0] NN_STORE = 8'h55;
  localparam logic [7:0] NN_FETCH = 8'h65;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_RDA, S_RDD, S_ROW, S_TICK,
    S_FA, S_FB, S_FC, S_RX, S_RY, S_EXEC,
    S_BCD, S_STR, S_STW, S_LDA, S_LDD,
    S_DRA, S_DRD, S_DRF, S_DONE
  } state_t;

  typedef struct packed {
    state_t step;
    logic   take;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] op;
    logic        cnt_last;
  } stat_t;

endpackage

// ===== rtl/c8x_ram.sv =====
// generic single-port ram with registered read
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/c8x_ctrl.sv =====
// sequencing state machine of the chip-8 executor
module c8x_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           out_tready,
  input  c8x_pkg::stat_t stat,
  output logic           in_tready,
  output logic           out_tvalid,
  output c8x_pkg::cmd_t  cmd
);
  import c8x_pkg::*;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic [3:0] grp;
  logic [7:0] nn;

  assign out_free = !out_valid_r || out_tready;
  assign grp      = stat.op[15:12];
  assign nn       = stat.op[7:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (stat.kind)
            KIND_LOAD: state_nxt = S_LOAD;
            KIND_EXEC: state_nxt = S_FA;
            KIND_READ: state_nxt = S_RDA;
            KIND_ROW:  state_nxt = S_ROW;
            KIND_TICK: state_nxt = S_TICK;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_LOAD, S_RDD, S_ROW, S_TICK: state_nxt = S_DONE;
      S_RDA: state_nxt = S_RDD;
      S_FA:  state_nxt = S_FB;
      S_FB:  state_nxt = S_FC;
      S_FC:  state_nxt = S_RX;
      S_RX:  state_nxt = S_RY;
      S_RY:  state_nxt = S_EXEC;
      S_EXEC: begin
        priority if (grp == GRP_DRW) begin
          state_nxt = (stat.op[3:0] == 4'd0) ? S_DRF : S_DRA;
        end else if (grp == GRP_MISC && nn == NN_BCD) begin
          state_nxt = S_BCD;
        end else if (grp == GRP_MISC && nn == NN_STORE) begin
          state_nxt = S_STR;
        end else if (grp == GRP_MISC && nn == NN_FETCH) begin
          state_nxt = S_LDA;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BCD: state_nxt = stat.cnt_last ? S_DONE : S_BCD;
      S_STR: state_nxt = S_STW;
      S_STW: state_nxt = stat.cnt_last ? S_DONE : S_STR;
      S_LDA: state_nxt = S_LDD;
      S_LDD: state_nxt = stat.cnt_last ? S_DONE : S_LDA;
      S_DRA: state_nxt = S_DRD;
      S_DRD: state_nxt = stat.cnt_last ? S_DRF : S_DRA;
      S_DRF: state_nxt = S_DONE;
      S_DONE: state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.step     = state_r;
    cmd.take     = (state_r == S_IDLE) && in_tvalid;
    cmd.out_load = (state_r == S_DONE) && out_free;
    in_tready    = (state_r == S_IDLE);
    out_tvalid   = out_valid_r;
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/c8x_dp.sv =====
// datapath: registers, screen, stack, timers, main memory and result register
module c8x_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  c8x_pkg::cmd_t  cmd,
  input  logic [2:0]     in_tuser,
  input  logic [47:0]    in_tdata,
  input  logic           cfg_valid,
  input  logic [11:0]    cfg_data,
  output c8x_pkg::stat_t stat,
  output logic [95:0]    out_tdata
);
  import c8x_pkg::*;

  // captured item
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        data_r, data_nxt;
  logic [7:0]        rnd_r, rnd_nxt;
  logic [15:0]       keys_r, keys_nxt;

  // working registers
  logic [15:0] op_r, op_nxt;
  logic [7:0]  vx_r, vx_nxt;
  logic [7:0]  vy_r, vy_nxt;
  logic [7:0]  tmp_r, tmp_nxt;
  logic        hit_r, hit_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] rd_r, rd_nxt;
  logic        bad_r, bad_nxt;

  // architectural state
  logic [7:0]         regs_r [16];
  logic [7:0]         regs_nxt [16];
  logic [63:0]        screen_r [SCREEN_H];
  logic [63:0]        screen_nxt [SCREEN_H];
  logic [ADDR_W-1:0]  stack_r [STACK_DEPTH];
  logic [ADDR_W-1:0]  stack_nxt [STACK_DEPTH];
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [15:0]        i_r, i_nxt;
  logic [ADDR_W-1:0]  pc_r, pc_nxt;
  logic [7:0]         dt_r, dt_nxt;
  logic [7:0]         st_r, st_nxt;
  logic [ADDR_W-1:0]  font_r;
  logic [95:0]        out_r;

  // memory port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // opcode fields
  logic [3:0]        grp, ox, oy, on;
  logic [7:0]        nn;
  logic [ADDR_W-1:0] nnn;
  assign grp = op_r[15:12];
  assign ox  = op_r[11:8];
  assign oy  = op_r[7:4];
  assign on  = op_r[3:0];
  assign nn  = op_r[7:0];
  assign nnn = op_r[11:0];

  // single read ports of register file and screen
  logic [3:0]       reg_ra;
  logic [7:0]       reg_rd;
  logic [ROW_W-1:0] scr_ra;
  logic [63:0]      scr_rd;
  logic [ROW_W-1:0] draw_row;

  assign draw_row = vy_r[ROW_W-1:0] + ROW_W'(cnt_r);

  always_comb begin
    unique case (cmd.step)
      S_RX:    reg_ra = (grp == GRP_JPV0) ? 4'd0 : ox;
      S_RY:    reg_ra = oy;
      default: reg_ra = cnt_r;
    endcase
  end
  assign reg_rd = regs_r[reg_ra];
  assign scr_ra = (cmd.step == S_ROW) ? addr_r[ROW_W-1:0] : draw_row;
  assign scr_rd = screen_r[scr_ra];

  // loop end
  logic [3:0] lim;
  always_comb begin
    priority if (grp == GRP_DRW)     lim = on - 4'd1;
    else if (nn == NN_BCD)           lim = 4'd2;
    else                             lim = ox;
  end
  assign stat.kind     = in_tuser;
  assign stat.op       = op_r;
  assign stat.cnt_last = (cnt_r == lim);

  // decimal digits of vx
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens, ones;
  logic [7:0]  digit;
  always_comb begin
    priority if (vx_r >= 8'd200) hund = 2'd2;
    else if (vx_r >= 8'd100)     hund = 2'd1;
    else                         hund = 2'd0;
    rem       = 7'(vx_r - 8'(hund) * 8'd100);
    tens_prod = 15'(rem) * 15'd205;
    tens      = tens_prod[14:11];
    ones      = 4'(rem - 7'(tens) * 7'd10);
    unique case (cnt_r[1:0])
      2'd0:    digit = {6'd0, hund};
      2'd1:    digit = {4'd0, tens};
      default: digit = {4'd0, ones};
    endcase
  end

  // sprite row mask, straight from the byte just read
  logic [63:0] wide, mask;
  logic [6:0]  lsh;
  assign wide = {mem_rdata, 56'd0};
  assign lsh  = 7'd64 - {1'b0, vx_r[COL_W-1:0]};
  assign mask = (wide >> vx_r[COL_W-1:0]) | (wide << lsh);

  // stack helpers
  logic [DEPTH_W-1:0] push_d, push_i, pop_i;
  assign push_d = (depth_r + 1'b1 >= DEPTH_W'(STACK_DEPTH)) ? DEPTH_W'(1)
                                                            : depth_r + 1'b1;
  assign push_i = push_d - 1'b1;
  assign pop_i  = depth_r - 1'b1;

  logic [ADDR_W-1:0] pc2;
  logic [8:0]        sum9;
  logic [15:0]       font_addr;
  logic              key;
  assign pc2       = pc_r + ADDR_W'(2);
  assign sum9      = {1'b0, vx_r} + {1'b0, vy_r};
  assign font_addr = {4'd0, font_r} + 16'(vx_r[3:0]) * 16'd5;
  assign key       = keys_r[vx_r[3:0]];

  always_comb begin
    addr_nxt = addr_r;  data_nxt = data_r;
    rnd_nxt  = rnd_r;   keys_nxt = keys_r;
    op_nxt   = op_r;    vx_nxt   = vx_r;    vy_nxt   = vy_r;
    tmp_nxt  = tmp_r;   hit_nxt  = hit_r;   cnt_nxt  = cnt_r;
    rd_nxt   = rd_r;    bad_nxt  = bad_r;
    regs_nxt   = regs_r;
    screen_nxt = screen_r;
    stack_nxt  = stack_r;
    depth_nxt  = depth_r;
    i_nxt  = i_r;  pc_nxt = pc_r;  dt_nxt = dt_r;  st_nxt = st_r;
    mem_we    = 1'b0;
    mem_addr  = pc_r;
    mem_wdata = data_r;

    unique case (cmd.step)
      S_IDLE: begin
        if (cmd.take) begin
          addr_nxt = in_tdata[11:0];
          data_nxt = in_tdata[19:12];
          rnd_nxt  = in_tdata[27:20];
          keys_nxt = in_tdata[43:28];
        end
        cnt_nxt = 4'd0;
        hit_nxt = 1'b0;
        bad_nxt = 1'b0;
        rd_nxt  = 64'd0;
      end
      S_LOAD: begin
        mem_we   = 1'b1;
        mem_addr = addr_r;
      end
      S_RDA: mem_addr = addr_r;
      S_RDD: rd_nxt = {56'd0, mem_rdata};
      S_ROW: rd_nxt = scr_rd;
      S_TICK: begin
        if (dt_r != 8'd0) dt_nxt = dt_r - 8'd1;
        if (st_r != 8'd0) st_nxt = st_r - 8'd1;
      end
      S_FA: mem_addr = pc_r;
      S_FB: begin
        mem_addr     = pc_r + ADDR_W'(1);
        op_nxt[15:8] = mem_rdata;
      end
      S_FC: op_nxt[7:0] = mem_rdata;
      S_RX: vx_nxt = reg_rd;
      S_RY: vy_nxt = reg_rd;
      S_EXEC: begin
        pc_nxt = pc2;
        unique case (grp)
          GRP_SYS: begin
            if (op_r == OP_CLS) begin
              for (int r = 0; r < SCREEN_H; r++) screen_nxt[r] = 64'd0;
            end else if (op_r == OP_RET) begin
              if (depth_r == '0) begin
                pc_nxt = PC_START + ADDR_W'(2);
              end else begin
                depth_nxt = pop_i;
                pc_nxt    = stack_r[pop_i[SP_W-1:0]] + ADDR_W'(2);
              end
            end
          end
          GRP_JP: pc_nxt = nnn;
          GRP_CALL: begin
            depth_nxt                  = push_d;
            stack_nxt[push_i[SP_W-1:0]] = pc_r;
            pc_nxt                     = nnn;
          end
          GRP_SEI:  if (vx_r == nn) pc_nxt = pc2 + ADDR_W'(2);
          GRP_SNEI: if (vx_r != nn) pc_nxt = pc2 + ADDR_W'(2);
          GRP_SE:   if (vx_r == vy_r) pc_nxt = pc2 + ADDR_W'(2);
          GRP_SNE:  if (vx_r != vy_r) pc_nxt = pc2 + ADDR_W'(2);
          GRP_LDI:  regs_nxt[ox] = nn;
          GRP_ADDI: regs_nxt[ox] = vx_r + nn;
          GRP_ALU: begin
            // vx first, then the flag so that vf wins when x is f
            unique case (on)
              ALU_MOV: regs_nxt[ox] = vy_r;
              ALU_OR:  regs_nxt[ox] = vx_r | vy_r;
              ALU_AND: regs_nxt[ox] = vx_r & vy_r;
              ALU_XOR: regs_nxt[ox] = vx_r ^ vy_r;
              ALU_ADD: begin
                regs_nxt[ox] = sum9[7:0];
                regs_nxt[15] = {7'd0, sum9[8]};
              end
              ALU_SUB: begin
                regs_nxt[ox] = vx_r - vy_r;
                regs_nxt[15] = {7'd0, vx_r >= vy_r};
              end
              ALU_SHR: begin
                regs_nxt[ox] = {1'b0, vy_r[7:1]};
                regs_nxt[15] = {7'd0, vy_r[0]};
              end
              ALU_RSB: begin
                regs_nxt[ox] = vy_r - vx_r;
                regs_nxt[15] = {7'd0, vy_r >= vx_r};
              end
              ALU_SHL: begin
                regs_nxt[ox] = {vy_r[6:0], 1'b0};
                regs_nxt[15] = {7'd0, vy_r[7]};
              end
              default: bad_nxt = 1'b1;
            endcase
          end
          GRP_SETI: i_nxt = {4'd0, nnn};
          GRP_JPV0: pc_nxt = nnn + ADDR_W'(vx_r);
          GRP_RND:  regs_nxt[ox] = rnd_r & nn;
          GRP_DRW:  cnt_nxt = 4'd0;
          GRP_KEY: begin
            if (nn == NN_SKP) begin
              if (key) pc_nxt = pc2 + ADDR_W'(2);
            end else if (nn == NN_SKNP) begin
              if (!key) pc_nxt = pc2 + ADDR_W'(2);
            end else begin
              bad_nxt = 1'b1;
            end
          end
          GRP_MISC: begin
            unique case (nn)
              NN_GETDT: regs_nxt[ox] = dt_r;
              NN_WAITK: ;
              NN_SETDT: dt_nxt = vx_r;
              NN_SETST: st_nxt = vx_r;
              NN_ADDIX: i_nxt = i_r + 16'(vx_r);
              NN_FONT:  i_nxt = font_addr;
              NN_BCD, NN_STORE, NN_FETCH: cnt_nxt = 4'd0;
              default:  bad_nxt = 1'b1;
            endcase
          end
          default: ;
        endcase
      end
      S_BCD: begin
        mem_we    = 1'b1;
        mem_addr  = i_r[ADDR_W-1:0] + ADDR_W'(cnt_r);
        mem_wdata = digit;
        cnt_nxt   = cnt_r + 4'd1;
      end
      S_STR: tmp_nxt = reg_rd;
      S_STW: begin
        mem_we    = 1'b1;
        mem_addr  = i_r[ADDR_W-1:0];
        mem_wdata = tmp_r;
        i_nxt     = i_r + 16'd1;
        cnt_nxt   = cnt_r + 4'd1;
      end
      S_LDA: mem_addr = i_r[ADDR_W-1:0];
      S_LDD: begin
        regs_nxt[cnt_r] = mem_rdata;
        i_nxt           = i_r + 16'd1;
        cnt_nxt         = cnt_r + 4'd1;
      end
      S_DRA: mem_addr = i_r[ADDR_W-1:0] + ADDR_W'(cnt_r);
      S_DRD: begin
        // merge the sprite row and note any pixel switched off
        screen_nxt[draw_row] = scr_rd ^ mask;
        hit_nxt              = hit_r | ((scr_rd & mask) != 64'd0);
        cnt_nxt              = cnt_r + 4'd1;
      end
      S_DRF: regs_nxt[15] = {7'd0, hit_r};
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 16; r++) regs_r[r] <= 8'd0;
      for (int r = 0; r < SCREEN_H; r++) screen_r[r] <= 64'd0;
      for (int r = 0; r < STACK_DEPTH; r++) stack_r[r] <= '0;
      depth_r <= '0;
      i_r     <= 16'd0;
      pc_r    <= PC_START;
      dt_r    <= 8'd0;
      st_r    <= 8'd0;
      font_r  <= FONT_RESET;
      cnt_r   <= 4'd0;
      hit_r   <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      regs_r   <= regs_nxt;
      screen_r <= screen_nxt;
      stack_r  <= stack_nxt;
      depth_r  <= depth_nxt;
      i_r      <= i_nxt;
      pc_r     <= pc_nxt;
      dt_r     <= dt_nxt;
      st_r     <= st_nxt;
      bad_r    <= bad_nxt;
      hit_r    <= hit_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_valid) font_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    data_r <= data_nxt;
    rnd_r  <= rnd_nxt;
    keys_r <= keys_nxt;
    op_r   <= op_nxt;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    tmp_r  <= tmp_nxt;
    rd_r   <= rd_nxt;
    if (cmd.out_load) begin
      out_r <= {2'd0, (st_r != 8'd0), bad_r, i_r, pc_r, rd_r};
    end
  end

  assign out_tdata = out_r;

endmodule

// ===== rtl/chip8_instruction_executor.sv =====
// top level of the chip-8 instruction executor
// One item at a time. A load, byte read, row read or tick does its memory, screen or
// timer step before the result; an executed instruction makes two fetch reads from the
// single-port main memory, two register reads through the one register-file read port,
// then the execute step and the result. FX33 then writes the three digits, FX55 and
// FX65 move each register in a register step and a memory step, and DXYN reads and
// merges each sprite row and then writes VF, every byte going through the one
// main-memory port; each sprite row is merged into the screen in the cycle its byte
// arrives. No clearing pass: the screen, registers and stack reset at once, and main
// memory holds garbage until the host loads it (font included; its base is the cfg register).
module chip8_instruction_executor (
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // address[11:0], data[19:12], random_byte[27:20],
                                  // keys_down[43:28], zero pad
  input  logic [2:0]  in_tuser,   // kind
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // read_data[63:0], program_counter[75:64],
                                  // index_value[91:76], bad_opcode[92],
                                  // sound_on[93], zero pad
  // font base register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);
  import c8x_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  c8x_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  c8x_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

  // busy once a transaction is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in progress");

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result overwrote a pending transaction");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

// ===== tb/sv/chip8_checker.sv =====
// result checker for the chip-8 executor: watches the channels, predicts and compares
module chip8_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [11:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import c8x_pkg::*;

  typedef struct packed {
    logic [63:0] read_data;
    logic [11:0] pc;
    logic [15:0] index;
    logic        bad;
    logic        sound;
  } cpu_result_t;

  logic [7:0]  mem [MEM_BYTES];
  logic [63:0] screen [SCREEN_H];
  logic [7:0]  vreg [16];
  logic [15:0] ireg;
  logic [11:0] pc;
  logic [11:0] calls [STACK_DEPTH];
  int          depth;
  logic [7:0]  delay_t, sound_t;
  logic [11:0] font_base;
  cpu_result_t awaited_results [$];

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    errors++;
    $display("mismatch in %s: got %h, expected %h", what, got, want);
  endtask

  function automatic logic [11:0] pop_return();
    if (depth == 0) return PC_START;
    depth--;
    return calls[depth];
  endfunction

  task automatic draw(input logic [7:0] vx, input logic [7:0] vy, input int rows);
    int x0, y0, row;
    logic [7:0]  b;
    logic [63:0] mask;
    logic        hit;
    x0 = vx % SCREEN_W;
    y0 = vy % SCREEN_H;
    hit = 0;
    for (int r = 0; r < rows; r++) begin
      b = mem[(ireg + r) & 16'hFFF];
      mask = '0;
      for (int c = 0; c < 8; c++)
        if (b[7-c]) mask[63 - ((x0 + c) % SCREEN_W)] = 1'b1;
      row = (y0 + r) % SCREEN_H;
      if ((screen[row] & mask) != 0) hit = 1;
      screen[row] ^= mask;
    end
    vreg[15] = {7'b0, hit};
  endtask

  // one instruction at pc; returns the unknown-opcode flag
  task automatic step_cpu(input logic [7:0] rnd, input logic [15:0] keys, output logic bad);
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy, f;
    logic [11:0] nnn, nxt;
    op  = {mem[pc], mem[pc + 12'd1]};
    x   = op[11:8];
    y   = op[7:4];
    n   = op[3:0];
    nn  = op[7:0];
    nnn = op[11:0];
    vx  = vreg[x];
    vy  = vreg[y];
    nxt = pc + 12'd2;
    bad = 0;
    case (op[15:12])
      GRP_SYS: begin
        if (op == OP_CLS) begin
          for (int r = 0; r < SCREEN_H; r++) screen[r] = '0;
        end else if (op == OP_RET) begin
          nxt = pop_return() + 12'd2;
        end
      end
      GRP_JP: nxt = nnn;
      GRP_CALL: begin
        depth++;
        if (depth >= STACK_DEPTH) depth = 1;
        calls[depth - 1] = pc;
        nxt = nnn;
      end
      GRP_SEI:  if (vx == nn) nxt += 12'd2;
      GRP_SNEI: if (vx != nn) nxt += 12'd2;
      GRP_SE:   if (vx == vy) nxt += 12'd2;
      GRP_LDI:  vreg[x] = nn;
      GRP_ADDI: vreg[x] = vx + nn;
      GRP_ALU: begin
        case (n)
          ALU_MOV: vreg[x] = vy;
          ALU_OR:  vreg[x] = vx | vy;
          ALU_AND: vreg[x] = vx & vy;
          ALU_XOR: vreg[x] = vx ^ vy;
          ALU_ADD: begin f = ({1'b0, vx} + vy) > 9'hFF; vreg[x] = vx + vy; vreg[15] = f; end
          ALU_SUB: begin f = vx >= vy; vreg[x] = vx - vy; vreg[15] = f; end
          ALU_SHR: begin f = vy[0]; vreg[x] = vy >> 1; vreg[15] = f; end
          ALU_RSB: begin f = vy >= vx; vreg[x] = vy - vx; vreg[15] = f; end
          ALU_SHL: begin f = vy[7]; vreg[x] = vy << 1; vreg[15] = f; end
          default: bad = 1;
        endcase
      end
      GRP_SNE:  if (vx != vy) nxt += 12'd2;
      GRP_SETI: ireg = {4'b0, nnn};
      GRP_JPV0: nxt = nnn + vreg[0];
      GRP_RND:  vreg[x] = rnd & nn;
      GRP_DRW:  draw(vx, vy, n);
      GRP_KEY: begin
        if (nn == NN_SKP) begin
          if (keys[vx[3:0]]) nxt += 12'd2;
        end else if (nn == NN_SKNP) begin
          if (!keys[vx[3:0]]) nxt += 12'd2;
        end else begin
          bad = 1;
        end
      end
      default: begin
        case (nn)
          NN_GETDT: vreg[x] = delay_t;
          NN_WAITK: ;
          NN_SETDT: delay_t = vx;
          NN_SETST: sound_t = vx;
          NN_ADDIX: ireg = ireg + vx;
          NN_FONT:  ireg = {4'b0, font_base} + 16'(vx[3:0]) * 16'd5;
          NN_BCD: begin
            mem[ireg[11:0]]         = vx / 100;
            mem[ireg[11:0] + 12'd1] = (vx / 10) % 10;
            mem[ireg[11:0] + 12'd2] = vx % 10;
          end
          NN_STORE:
            for (int i = 0; i <= x; i++) begin
              mem[ireg[11:0]] = vreg[i];
              ireg++;
            end
          NN_FETCH:
            for (int i = 0; i <= x; i++) begin
              vreg[i] = mem[ireg[11:0]];
              ireg++;
            end
          default: bad = 1;
        endcase
      end
    endcase
    pc = nxt;
  endtask

  always @(posedge clk) begin
    cpu_result_t want, got;
    logic        bad;
    if (!rst_n) begin
      for (int r = 0; r < SCREEN_H; r++) screen[r] = '0;
      for (int i = 0; i < 16; i++) vreg[i] = '0;
      for (int i = 0; i < STACK_DEPTH; i++) calls[i] = '0;
      ireg = '0;
      pc = PC_START;
      depth = 0;
      delay_t = '0;
      sound_t = '0;
      font_base = FONT_RESET;
      errors = 0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) font_base = cfg_data;
      if (in_tvalid && in_tready) begin
        want = '0;
        case (in_tuser)
          KIND_LOAD: mem[in_tdata[11:0]] = in_tdata[19:12];
          KIND_EXEC: begin step_cpu(in_tdata[27:20], in_tdata[43:28], bad); want.bad = bad; end
          KIND_READ: want.read_data = {56'b0, mem[in_tdata[11:0]]};
          KIND_ROW:  want.read_data = screen[in_tdata[4:0]];
          KIND_TICK: begin
            if (delay_t != 0) delay_t--;
            if (sound_t != 0) sound_t--;
          end
          default: ;
        endcase
        want.pc    = pc;
        want.index = ireg;
        want.sound = sound_t != 0;
        awaited_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[63:0], out_tdata[75:64], out_tdata[91:76], out_tdata[92],
               out_tdata[93]};
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result", out_tdata[63:0], '0);
        end else begin
          want = awaited_results.pop_front();
          if (got.read_data != want.read_data)
            flag_mismatch("read_data", got.read_data, want.read_data);
          if (got.pc != want.pc) flag_mismatch("program_counter", got.pc, want.pc);
          if (got.index != want.index) flag_mismatch("index_value", got.index, want.index);
          if (got.bad != want.bad) flag_mismatch("bad_opcode", got.bad, want.bad);
          if (got.sound != want.sound) flag_mismatch("sound_on", got.sound, want.sound);
        end
      end
    end
    pending = awaited_results.size();
  end
endmodule

// ===== tb/sv/testbench.sv =====
// stimulus and verdict for the chip-8 executor testbench
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import c8x_pkg::*;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [47:0] in_tdata;    // address, data, random_byte, keys_down, zero pad
  logic [2:0]  in_tuser;    // kind
  logic        out_tvalid, out_tready;
  logic [95:0] out_tdata;   // read_data, program_counter, index_value, bad_opcode, sound_on
  logic        cfg_valid, cfg_ready;
  logic [11:0] cfg_data;
  int          errors, pending;

  int          n_sent, n_seen, n_exec, idle_cycles;
  logic [11:0] cur_pc;      // program counter reported by the latest result
  logic [15:0] cur_i;       // index register reported by the latest result
  logic        calm;        // no idling on either side while set
  bit          written [MEM_BYTES];  // main memory bytes loaded so far

  chip8_instruction_executor uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  chip8_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_data,
    .errors, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure, count results, track pc and index
  always @(posedge clk) begin
    if (!rst_n) begin
      n_seen <= 0;
      cur_pc <= PC_START;
      cur_i  <= '0;
    end else if (out_tvalid && out_tready) begin
      n_seen <= n_seen + 1;
      cur_pc <= out_tdata[75:64];
      cur_i  <= out_tdata[91:76];
    end
    out_tready <= calm || ($urandom_range(99) >= 37);
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("watchdog expired with %0d results outstanding", n_sent - n_seen);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one input transaction, then wait for its result (the block runs one item at a time)
  task automatic send(input logic [2:0] kind, input logic [11:0] addr, input logic [7:0] data,
                      input logic [7:0] rnd, input logic [15:0] keys);
    while (!calm && $urandom_range(99) < 37) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, keys, rnd, data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 1'b0;
    n_sent++;
    if (kind == KIND_EXEC) n_exec++;
    if (kind == KIND_LOAD) written[addr] = 1'b1;
    while (n_seen != n_sent) @(posedge clk);
  endtask

  // load a random byte where memory is still unwritten
  task automatic ensure_loaded(input logic [11:0] addr);
    if (!written[addr])
      send(KIND_LOAD, addr, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // place an opcode at the current pc and execute it, with the bytes it reads loaded
  task automatic run_op(input logic [15:0] op);
    int span;
    span = 0;
    if (op[15:12] == GRP_DRW)
      span = int'(op[3:0]);
    else if (op[15:12] == GRP_MISC && op[7:0] == NN_FETCH)
      span = int'(op[11:8]) + 1;
    for (int k = 0; k < span; k++) ensure_loaded(cur_i[11:0] + 12'(k));
    send(KIND_LOAD, cur_pc, op[15:8], 8'($urandom), 16'($urandom));
    send(KIND_LOAD, cur_pc + 12'd1, op[7:0], 8'($urandom), 16'($urandom));
    send(KIND_EXEC, 12'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // only while idle: every result has been seen by now
  task automatic write_font_base(input logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_op();
    logic [15:0] op;
    op = 16'($urandom);
    case (op[15:12])
      GRP_SYS: begin
        case ($urandom_range(2))
          0: op = OP_CLS;
          1: op = OP_RET;
          default: ;
        endcase
      end
      GRP_DRW: if ($urandom_range(3) != 0) op[3:0] = 4'($urandom_range(5));
      GRP_KEY: begin
        case ($urandom_range(2))
          0: op[7:0] = NN_SKP;
          1: op[7:0] = NN_SKNP;
          default: ;
        endcase
      end
      GRP_MISC: begin
        case ($urandom_range(11))
          0: op[7:0] = NN_GETDT;
          1: op[7:0] = NN_WAITK;
          2: op[7:0] = NN_SETDT;
          3: op[7:0] = NN_SETST;
          4: op[7:0] = NN_ADDIX;
          5: op[7:0] = NN_FONT;
          6: op[7:0] = NN_BCD;
          7: op[7:0] = NN_STORE;
          8: op[7:0] = NN_FETCH;
          default: ;
        endcase
      end
      default: ;
    endcase
    return op;
  endfunction

  // mostly instructions with random content, the rest loads, reads, ticks and unused kinds
  task automatic random_phase(input int rounds);
    logic [2:0]  k;
    logic [11:0] a;
    for (int i = 0; i < rounds; i++) begin
      if ($urandom_range(99) < 55) begin
        run_op(random_op());
      end else begin
        k = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        a = 12'($urandom);
        if (k == KIND_READ) ensure_loaded(a);
        send(k, a, 8'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = KIND_LOAD;
    cfg_valid = 0;
    cfg_data = '0;
    n_sent = 0;
    n_exec = 0;
    calm = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with the font base at its top
    write_font_base(12'hFFF);
    run_op(OP_CLS);
    run_op(16'h6AFF);              // VA = 255
    run_op(16'h6B01);
    run_op(16'h8AB4);              // add with carry out
    run_op(16'h8AB5);              // subtract with borrow
    run_op(16'h8AB7);
    run_op(16'h8FB6);              // shift into VF itself
    run_op(16'h8ABE);
    run_op(16'hFA29);              // font address near the top of memory
    run_op(16'hA000);
    run_op(16'hD0B5);
    run_op(16'hD0B5);              // same sprite again: collision, erase
    run_op(16'hD000);              // zero rows draws nothing
    run_op(16'h8AB8);              // unknown alu code
    run_op(16'hE0FF);              // unknown key form
    run_op(16'hF0FF);              // unknown misc form
    run_op(16'h0123);              // system call ignored
    run_op(OP_RET);                // return on an empty stack
    run_op(16'hFA18);              // sound on
    send(KIND_TICK, '0, '0, '0, '0);
    run_op(16'hFFFF & 16'hFF55);   // store all sixteen registers
    send(KIND_ROW, 12'hFFF, '0, '0, '0);
    for (int i = 0; i < STACK_DEPTH + 1; i++)
      run_op({GRP_CALL, 12'($urandom)});   // overflow wraps the stack
    run_op(OP_RET);

    write_font_base(12'h000);
    random_phase(60);
    calm = 0;
    random_phase(60);
    write_font_base(12'($urandom));
    random_phase(120);
    write_font_base(FONT_RESET);
    random_phase(120);

    while (n_seen != n_sent) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("ran %0d transactions, %0d of them instructions, memory loaded on demand,",
             n_sent, n_exec);
    $display("under four font base settings with random gaps on both sides");
    if (errors == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
